// File: hw/rtl/rpme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpme_pkg
// Shared types, codes and helpers of the RNA pair move enumerator.
// ----------------------------------------------------------------------------
package rpme_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned JPOS_W = POS_W + 1;  // scan index, may run one past 127
  localparam int unsigned BASE_W = 3;
  localparam int unsigned GAP_W  = 6;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned CFGI_W = 1;

  localparam int unsigned RESULT_CAP = 60;
  localparam int unsigned CNT_W      = 6;

  localparam logic [POS_W-1:0] SEQ_LEN_RESET = 7'd64;
  localparam logic [GAP_W-1:0] MIN_GAP_RESET = 6'd3;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_SEQ_LENGTH = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_MIN_GAP    = 1'b1;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd3;

  // nucleotide codes
  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_U = 3'd3;
  localparam logic [BASE_W-1:0] BASE_T = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic start_load;
    logic start_row;
    logic row_eval;
    logic scan_adv;
    logic take_hit;
    logic emit_final;
  } rpme_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic pend_valid;
    logic row_ok;
    logic row_paired;
    logic row_next_end;
    logic scan_hit;
    logic scan_close;
    logic scan_next_end;
    logic cap_hit;
  } rpme_stat_t;

  function automatic logic pairs_ok(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b);
    logic ok;
    ok = 1'b0;
    case (a)
      BASE_A:  ok = (b == BASE_U) || (b == BASE_T);
      BASE_C:  ok = (b == BASE_G);
      BASE_G:  ok = (b == BASE_C) || (b == BASE_U) || (b == BASE_T);
      BASE_U:  ok = (b == BASE_A) || (b == BASE_G);
      BASE_T:  ok = (b == BASE_A) || (b == BASE_G);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rpme_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpme_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/rpme_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpme_ctrl
// Sequencer: accepts a transaction, walks the row scan, issues the final result.
// ----------------------------------------------------------------------------
module rpme_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_opcode,
  output logic                     in_ready,
  input  wire rpme_pkg::rpme_stat_t stat,
  output rpme_pkg::rpme_cmd_t      cmd
);
  import rpme_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       stall;

  // a new hit needs the output slot only when an earlier one is still pending
  assign stall = stat.scan_hit && stat.pend_valid && !stat.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd.start_load = 1'b1;
            state_nxt      = ST_FIN;
          end else begin
            cmd.start_row = 1'b1;
            state_nxt     = stat.row_ok ? ST_ROW : ST_FIN;
          end
        end
      end
      ST_ROW: begin
        cmd.row_eval = 1'b1;
        state_nxt    = (stat.row_paired || stat.row_next_end) ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.scan_adv = 1'b1;
          cmd.take_hit = stat.scan_hit;
          if (stat.scan_close || stat.scan_next_end || (stat.scan_hit && stat.cap_hit)) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_final_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_final |-> stat.out_free)
    else $error("final result issued while output slot busy");

  a_hit_push_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_hit && stat.pend_valid) |-> stat.out_free)
    else $error("pending insert pushed while output slot busy");

  a_row_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |-> $past(cmd.start_row))
    else $error("row evaluation without a row transaction");

endmodule
`default_nettype wire

// File: hw/rtl/rpme_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpme_dpath
// Sequence store, config registers, scan pointer, pending result and output
// register.
// ----------------------------------------------------------------------------
module rpme_dpath #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rpme_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [rpme_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic [rpme_pkg::POS_W-1:0]   in_position,
  input  wire logic [rpme_pkg::BASE_W-1:0]  in_base_code,
  input  wire logic [rpme_pkg::POS_W-1:0]   in_partner_pos,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic      [rpme_pkg::POS_W-1:0]   out_move_left,
  output logic      [rpme_pkg::POS_W-1:0]   out_move_right,
  output logic      [rpme_pkg::KIND_W-1:0]  out_move_kind,
  output logic                              out_last_of_row,
  input  wire rpme_pkg::rpme_cmd_t          cmd,
  output rpme_pkg::rpme_stat_t              stat
);
  import rpme_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_LEN);
  localparam int unsigned XW     = (AW > JPOS_W) ? AW : JPOS_W;
  localparam int unsigned MAXC   = (MAX_LEN > 127) ? 127 : MAX_LEN;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAXC);
  localparam int unsigned ENT_W  = BASE_W + POS_W;

  logic [POS_W-1:0]  seq_len_r;
  logic [GAP_W-1:0]  min_gap_r;
  logic [POS_W-1:0]  len;

  logic [POS_W-1:0]  i_r;
  logic [JPOS_W-1:0] j_r;
  logic [BASE_W-1:0] bi_r;
  logic [CNT_W-1:0]  cnt_r;

  logic              pend_valid_r;
  logic [POS_W-1:0]  pend_left_r;
  logic [POS_W-1:0]  pend_right_r;
  logic [KIND_W-1:0] pend_kind_r;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_left_r;
  logic [POS_W-1:0]  out_right_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_last_r;

  logic [ENT_W-1:0]  rdata;
  logic [BASE_W-1:0] rd_base;
  logic [POS_W-1:0]  rd_partner;
  logic              ram_we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [XW-1:0]     waddr_ext;
  logic [XW-1:0]     raddr_ext;
  logic [JPOS_W-1:0] rd_pos;

  logic [JPOS_W-1:0] i_next;
  logic [JPOS_W-1:0] q_ext;
  logic [JPOS_W-1:0] j_step;
  logic [JPOS_W-1:0] pair_dist;
  logic              scan_open;
  logic              push_hit;

  assign len = (seq_len_r < MAX_POS) ? seq_len_r : MAX_POS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= SEQ_LEN_RESET;
      min_gap_r <= MIN_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEQ_LENGTH: seq_len_r <= cfg_wdata;
        CFG_MIN_GAP:    min_gap_r <= cfg_wdata[GAP_W-1:0];
        default:        ;
      endcase
    end
  end

  // store: one entry per position, base over partner
  assign ram_we    = cmd.start_load && (in_position != '0) && (in_position <= MAX_POS);
  assign waddr_ext = XW'(in_position) - XW'(1);
  assign waddr     = waddr_ext[AW-1:0];

  assign rd_base    = rdata[ENT_W-1 -: BASE_W];
  assign rd_partner = rdata[POS_W-1:0];

  assign i_next    = JPOS_W'(i_r) + JPOS_W'(1);
  assign q_ext     = JPOS_W'(rd_partner);
  assign scan_open = q_ext > j_r;
  // jump over an enclosed helix to the position after its closing partner
  assign j_step    = scan_open ? (q_ext + JPOS_W'(1)) : (j_r + JPOS_W'(1));
  assign pair_dist = j_r - JPOS_W'(i_r);

  always_comb begin
    if (cmd.start_row) begin
      rd_pos = JPOS_W'(in_position);
    end else if (cmd.row_eval) begin
      rd_pos = i_next;
    end else if (cmd.scan_adv) begin
      rd_pos = j_step;
    end else begin
      rd_pos = j_r;
    end
  end

  assign raddr_ext = XW'(rd_pos) - XW'(1);
  assign raddr     = raddr_ext[AW-1:0];

  rpme_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   ({in_base_code, in_partner_pos}),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  always_comb begin
    stat.out_free      = !out_valid_r || out_ready;
    stat.pend_valid    = pend_valid_r;
    stat.row_ok        = (in_position != '0) && (in_position <= len);
    stat.row_paired    = rd_partner != '0;
    stat.row_next_end  = i_next > JPOS_W'(len);
    stat.scan_hit      = (rd_partner == '0) && (pair_dist > JPOS_W'(min_gap_r))
                         && pairs_ok(bi_r, rd_base);
    stat.scan_close    = (rd_partner != '0) && !scan_open;
    stat.scan_next_end = j_step > JPOS_W'(len);
    stat.cap_hit       = cnt_r == CNT_W'(RESULT_CAP - 1);
  end

  assign push_hit = cmd.take_hit && pend_valid_r;

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.start_row) begin
      i_r <= in_position;
    end
    if (cmd.row_eval) begin
      bi_r <= rd_base;
      j_r  <= i_next;
    end else if (cmd.scan_adv) begin
      j_r <= j_step;
    end
  end

  // pending result: held back until it is known whether it closes the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cmd.start_load) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.start_row || cmd.emit_final) begin
        pend_valid_r <= 1'b0;
        cnt_r        <= '0;
      end else if (cmd.row_eval) begin
        pend_valid_r <= (rd_partner != '0) && (rd_partner >= i_r);
      end else if (cmd.take_hit) begin
        pend_valid_r <= 1'b1;
        cnt_r        <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      pend_left_r  <= '0;
      pend_right_r <= '0;
      pend_kind_r  <= KIND_ACK;
    end else if (cmd.row_eval) begin
      pend_left_r  <= i_r;
      pend_right_r <= rd_partner;
      pend_kind_r  <= KIND_DELETE;
    end else if (cmd.take_hit) begin
      pend_left_r  <= i_r;
      pend_right_r <= j_r[POS_W-1:0];
      pend_kind_r  <= KIND_INSERT;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_hit || cmd.emit_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_hit) begin
      out_left_r  <= pend_left_r;
      out_right_r <= pend_right_r;
      out_kind_r  <= pend_kind_r;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_final) begin
      out_left_r  <= pend_valid_r ? pend_left_r  : '0;
      out_right_r <= pend_valid_r ? pend_right_r : '0;
      out_kind_r  <= pend_valid_r ? pend_kind_r  : KIND_NONE;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_move_left   = out_left_r;
  assign out_move_right  = out_right_r;
  assign out_move_kind   = out_kind_r;
  assign out_last_of_row = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RESULT_CAP))
    else $error("insert count beyond row cap");

  a_scan_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_hit |-> (j_r > JPOS_W'(i_r)) && (j_r <= JPOS_W'(len)))
    else $error("insert partner outside scan window");

  a_push_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (push_hit || cmd.emit_final) |=> out_valid_r)
    else $error("pushed result not presented");

endmodule
`default_nettype wire

// File: hw/rtl/rna_pair_move_enumerator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rna_pair_move_enumerator_core
// Holds an RNA sequence with its pair table and lists the insert/delete moves
// of one row per request.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | opcode, position, base_code, partner_pos
//   out_    | output    | out_valid/out_ready | move_left, move_right, move_kind, last_of_row
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata (seq_length, min_gap)
//
// A load goes through the accept and final states, as does a row outside the
// length. A row goes through accept, row evaluation, one scan step per scanned
// position (at most seq_length) and the final state; the store has one registered
// read port; the scan reads one entry per cycle unless stalled; jumps over helices
// cost nothing extra. One transaction is in flight at a time; a full output
// register stalls the scan. Reset clears control and config; the store is not cleared.
// ----------------------------------------------------------------------------
module rna_pair_move_enumerator_core #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rpme_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [rpme_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_opcode,
  input  wire logic [rpme_pkg::POS_W-1:0]   in_position,
  input  wire logic [rpme_pkg::BASE_W-1:0]  in_base_code,
  input  wire logic [rpme_pkg::POS_W-1:0]   in_partner_pos,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [rpme_pkg::POS_W-1:0]   out_move_left,
  output logic      [rpme_pkg::POS_W-1:0]   out_move_right,
  output logic      [rpme_pkg::KIND_W-1:0]  out_move_kind,
  output logic                              out_last_of_row
);
  import rpme_pkg::*;

  rpme_cmd_t  cmd;
  rpme_stat_t stat;

  rpme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpme_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_position     (in_position),
    .in_base_code    (in_base_code),
    .in_partner_pos  (in_partner_pos),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_move_left   (out_move_left),
    .out_move_right  (out_move_right),
    .out_move_kind   (out_move_kind),
    .out_last_of_row (out_last_of_row),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
`default_nettype wire
